// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: transaction
// payloads, the command word passed from front end to back end, and codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Input operation codes
  localparam logic [2:0] OP_PRINT_CHAR  = 3'd0;
  localparam logic [2:0] OP_NEWLINE     = 3'd1;
  localparam logic [2:0] OP_BACKSPACE   = 3'd2;
  localparam logic [2:0] OP_PRINT_INT   = 3'd3;
  localparam logic [2:0] OP_MOVE_CURSOR = 3'd4;

  // Output write kinds
  localparam logic WK_MEM  = 1'b0;
  localparam logic WK_PORT = 1'b1;

  // CRTC ports and cursor location register indexes
  localparam logic [15:0] CRTC_INDEX_PORT = 16'h03D4;
  localparam logic [15:0] CRTC_DATA_PORT  = 16'h03D5;
  localparam logic [7:0]  CRTC_CURSOR_LO  = 8'h0F;
  localparam logic [7:0]  CRTC_CURSOR_HI  = 8'h0E;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Configuration register
  localparam logic [1:0] ADDR_TEXT_ATTR = 2'd0;
  localparam logic [7:0] ATTR_RESET     = 8'h07;

  // Divide by ten through a reciprocal: q = (m * DIV10_MUL) >> DIV10_SHIFT
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          QUO_W       = 29;

  // Offset to cell position: shift used with the per-cell reciprocal
  localparam int CUR_DIV_SHIFT = 18;

  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int NDIG_W     = 4;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        char_code;
    logic signed [31:0] number;
    logic [7:0]        target_row;
    logic [7:0]        target_col;
  } tcw_in_t;

  typedef struct packed {
    logic        write_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last;
  } tcw_out_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_NUMBER,
    CMD_MOVE
  } cmd_kind_t;

  // Classified command, decimal digits held least significant first
  typedef struct packed {
    cmd_kind_t                              kind;
    logic [7:0]                             char_code;
    logic                                   neg;
    logic [NDIG_W-1:0]                      ndig;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]     digits;
    logic [15:0]                            pos;
  } tcw_cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_SUB,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CELL_CH,
    BK_CELL_AT,
    BK_BS_AT,
    BK_BS_SP,
    BK_POS,
    BK_CUR_LO_IDX,
    BK_CUR_LO,
    BK_CUR_HI_IDX,
    BK_CUR_HI
  } bk_state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console writer: turns print, newline, backspace, integer and
// cursor commands into cell memory byte writes and CRTC port writes.
// ----------------------------------------------------------------------------
// Newline, and backspace at offset 0, compute the cursor position before
//   their first write; integers first pass the divide-by-ten loop.
// Throughput: one write per cycle from the back end sequencer while
//   out_ready is high; an integer takes up to 26 writes.
// Reset: synchronous, active low; offset 0, attribute 0x07, queue emptied.
module text_console_writer #(
  parameter int BYTES_PER_CELL = 2,
  parameter int COLUMNS        = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tcw_pkg::tcw_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [1:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [7:0]        attr_r, attr_nxt;
  logic              push_valid, push_ready;
  tcw_pkg::tcw_cmd_t push_cmd;
  logic              pop_valid, pop_ready;
  tcw_pkg::tcw_cmd_t pop_cmd;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == tcw_pkg::ADDR_TEXT_ATTR) ? {24'd0, attr_r} : 32'd0;

  always_comb begin
    attr_nxt = attr_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
        && (cfg_paddr == tcw_pkg::ADDR_TEXT_ATTR)) begin
      attr_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tcw_back #(
    .BYTES_PER_CELL (BYTES_PER_CELL),
    .COLUMNS        (COLUMNS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_attribute (attr_r),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

// ===== rtl/tcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transactions, classifies the operation and prepares a
// command: decimal digits for integers, cell position for cursor moves.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_in_t  in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output tcw_pkg::tcw_cmd_t push_cmd
);

  tcw_pkg::fr_state_t      state_r, state_nxt;
  tcw_pkg::tcw_cmd_t       cmd_r, cmd_nxt;
  logic [31:0]             mag_r, mag_nxt;
  logic [tcw_pkg::QUO_W-1:0] quo_r, quo_nxt;

  logic [63:0] prod;
  logic [31:0] raw;
  logic [31:0] rem32;
  logic [15:0] move_sum;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
  end

  assign in_ready   = (state_r == tcw_pkg::FR_IDLE);
  assign push_valid = (state_r == tcw_pkg::FR_PUSH);
  assign push_cmd   = cmd_r;

  // Classify, convert and hand over
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    mag_nxt   = mag_r;
    quo_nxt   = quo_r;
    raw       = in_data.number;
    prod      = 64'(mag_r) * 64'(tcw_pkg::DIV10_MUL);
    rem32     = mag_r - ({3'b000, quo_r} * 32'd10);
    move_sum  = (16'(in_data.target_row) * 16'(COLUMNS)) + 16'(in_data.target_col);

    case (state_r)
      tcw_pkg::FR_IDLE: begin
        if (in_valid) begin
          cmd_nxt.char_code = in_data.char_code;
          cmd_nxt.neg       = 1'b0;
          cmd_nxt.ndig      = '0;
          cmd_nxt.digits    = '0;
          cmd_nxt.pos       = move_sum;
          case (in_data.op)
            tcw_pkg::OP_PRINT_CHAR: begin
              cmd_nxt.kind = tcw_pkg::CMD_CHAR;
              state_nxt    = tcw_pkg::FR_PUSH;
            end
            tcw_pkg::OP_NEWLINE: begin
              cmd_nxt.kind = tcw_pkg::CMD_NEWLINE;
              state_nxt    = tcw_pkg::FR_PUSH;
            end
            tcw_pkg::OP_BACKSPACE: begin
              cmd_nxt.kind = tcw_pkg::CMD_BACKSPACE;
              state_nxt    = tcw_pkg::FR_PUSH;
            end
            tcw_pkg::OP_PRINT_INT: begin
              cmd_nxt.kind = tcw_pkg::CMD_NUMBER;
              cmd_nxt.neg  = raw[31];
              mag_nxt      = raw[31] ? (32'd0 - raw) : raw;
              state_nxt    = tcw_pkg::FR_MUL;
            end
            tcw_pkg::OP_MOVE_CURSOR: begin
              cmd_nxt.kind = tcw_pkg::CMD_MOVE;
              state_nxt    = tcw_pkg::FR_PUSH;
            end
            default: begin
              // drop unused codes
              state_nxt = tcw_pkg::FR_IDLE;
            end
          endcase
        end
      end
      tcw_pkg::FR_MUL: begin
        quo_nxt   = prod[tcw_pkg::DIV10_SHIFT +: tcw_pkg::QUO_W];
        state_nxt = tcw_pkg::FR_SUB;
      end
      tcw_pkg::FR_SUB: begin
        // store one digit, least significant first
        cmd_nxt.digits[cmd_r.ndig] = rem32[tcw_pkg::DIGIT_W-1:0];
        cmd_nxt.ndig = cmd_r.ndig + 1'b1;
        mag_nxt      = {3'b000, quo_r};
        state_nxt    = (quo_r == '0) ? tcw_pkg::FR_PUSH : tcw_pkg::FR_MUL;
      end
      tcw_pkg::FR_PUSH: begin
        if (push_ready) begin
          state_nxt = tcw_pkg::FR_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::FR_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tcw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tcw_pkg::tcw_cmd_t pop_cmd
);

  tcw_pkg::tcw_cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Carries out commands: owns the write offset, emits cell memory writes one
// per cycle unless out_ready stalls, and ends every command with four CRTC port writes.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int BYTES_PER_CELL = 2,
  parameter int COLUMNS        = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        text_attribute,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  tcw_pkg::tcw_cmd_t pop_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output tcw_pkg::tcw_out_t out_data
);

  localparam int LINE    = BYTES_PER_CELL * COLUMNS;
  localparam int COL_W   = $clog2(LINE);
  localparam int LINE_W  = COL_W + 1;
  localparam int CUR_MUL = ((1 << tcw_pkg::CUR_DIV_SHIFT) + BYTES_PER_CELL - 1)
                           / BYTES_PER_CELL;
  localparam int PROD_W  = tcw_pkg::CUR_DIV_SHIFT + 17;

  tcw_pkg::bk_state_t state_r, state_nxt;
  logic [15:0]        off_r, off_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [7:0]         ch_r, ch_nxt;
  logic [tcw_pkg::NDIG_W-1:0] rem_r, rem_nxt;
  logic [tcw_pkg::MAX_DIGITS-1:0][tcw_pkg::DIGIT_W-1:0] digits_r, digits_nxt;
  logic [15:0]        pos_r, pos_nxt;

  logic [16:0]        adv;
  logic [LINE_W-1:0]  colsum;
  logic [16:0]        nl_sum;
  logic [LINE_W-1:0]  col_back;
  logic [PROD_W-1:0]  cur_prod;
  logic               emit_ok;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::BK_IDLE;
      off_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      off_r   <= off_nxt;
      col_r   <= col_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    rem_r    <= rem_nxt;
    digits_r <= digits_nxt;
    pos_r    <= pos_nxt;
  end

  assign emit_ok = out_valid && out_ready;

  // Sequence writes and track offset and column position
  always_comb begin
    state_nxt  = state_r;
    off_nxt    = off_r;
    col_nxt    = col_r;
    ch_nxt     = ch_r;
    rem_nxt    = rem_r;
    digits_nxt = digits_r;
    pos_nxt    = pos_r;
    pop_ready  = 1'b0;
    out_valid  = 1'b0;
    out_data.write_kind    = tcw_pkg::WK_MEM;
    out_data.write_address = off_r;
    out_data.write_data    = ch_r;
    out_data.last          = 1'b0;

    adv      = {1'b0, off_r} + 17'(BYTES_PER_CELL);
    colsum   = {1'b0, col_r} + LINE_W'(BYTES_PER_CELL);
    nl_sum   = {1'b0, off_r} + (17'(LINE) - 17'(col_r));
    col_back = {1'b0, col_r} + LINE_W'(LINE) - LINE_W'(BYTES_PER_CELL);
    cur_prod = PROD_W'(off_r) * PROD_W'(CUR_MUL);

    case (state_r)
      tcw_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          ch_nxt     = pop_cmd.char_code;
          rem_nxt    = '0;
          digits_nxt = pop_cmd.digits;
          pos_nxt    = pop_cmd.pos;
          case (pop_cmd.kind)
            tcw_pkg::CMD_CHAR: begin
              state_nxt = tcw_pkg::BK_CELL_CH;
            end
            tcw_pkg::CMD_NEWLINE: begin
              off_nxt   = nl_sum[15:0];
              col_nxt   = nl_sum[16] ? nl_sum[COL_W-1:0] : '0;
              state_nxt = tcw_pkg::BK_POS;
            end
            tcw_pkg::CMD_BACKSPACE: begin
              if (off_r == 16'd0) begin
                state_nxt = tcw_pkg::BK_POS;
              end else begin
                // saturate at zero below one cell
                if (off_r < 16'(BYTES_PER_CELL)) begin
                  off_nxt = '0;
                  col_nxt = '0;
                end else begin
                  off_nxt = off_r - 16'(BYTES_PER_CELL);
                  col_nxt = (col_r >= COL_W'(BYTES_PER_CELL)) ?
                            (col_r - COL_W'(BYTES_PER_CELL)) : col_back[COL_W-1:0];
                end
                state_nxt = tcw_pkg::BK_BS_AT;
              end
            end
            tcw_pkg::CMD_NUMBER: begin
              if (pop_cmd.neg) begin
                ch_nxt  = tcw_pkg::CH_MINUS;
                rem_nxt = pop_cmd.ndig;
              end else begin
                ch_nxt  = tcw_pkg::CH_ZERO
                          + 8'(pop_cmd.digits[pop_cmd.ndig - 1'b1]);
                rem_nxt = pop_cmd.ndig - 1'b1;
              end
              state_nxt = tcw_pkg::BK_CELL_CH;
            end
            tcw_pkg::CMD_MOVE: begin
              state_nxt = tcw_pkg::BK_CUR_LO_IDX;
            end
            default: begin
              state_nxt = tcw_pkg::BK_IDLE;
            end
          endcase
        end
      end
      tcw_pkg::BK_CELL_CH: begin
        out_valid = 1'b1;
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_CELL_AT;
        end
      end
      tcw_pkg::BK_CELL_AT: begin
        out_valid              = 1'b1;
        out_data.write_address = off_r + 16'd1;
        out_data.write_data    = text_attribute;
        if (emit_ok) begin
          // advance one cell
          off_nxt = adv[15:0];
          if (adv[16]) begin
            col_nxt = adv[COL_W-1:0];
          end else if (colsum >= LINE_W'(LINE)) begin
            col_nxt = COL_W'(colsum - LINE_W'(LINE));
          end else begin
            col_nxt = colsum[COL_W-1:0];
          end
          if (rem_r != '0) begin
            ch_nxt    = tcw_pkg::CH_ZERO + 8'(digits_r[rem_r - 1'b1]);
            rem_nxt   = rem_r - 1'b1;
            state_nxt = tcw_pkg::BK_CELL_CH;
          end else begin
            state_nxt = tcw_pkg::BK_POS;
          end
        end
      end
      tcw_pkg::BK_BS_AT: begin
        out_valid              = 1'b1;
        out_data.write_address = off_r + 16'd1;
        out_data.write_data    = text_attribute;
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_BS_SP;
        end
      end
      tcw_pkg::BK_BS_SP: begin
        out_valid           = 1'b1;
        out_data.write_data = tcw_pkg::CH_SPACE;
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_POS;
        end
      end
      tcw_pkg::BK_POS: begin
        // cell position: offset divided by the cell size
        pos_nxt   = cur_prod[tcw_pkg::CUR_DIV_SHIFT +: 16];
        state_nxt = tcw_pkg::BK_CUR_LO_IDX;
      end
      tcw_pkg::BK_CUR_LO_IDX: begin
        out_valid              = 1'b1;
        out_data.write_kind    = tcw_pkg::WK_PORT;
        out_data.write_address = tcw_pkg::CRTC_INDEX_PORT;
        out_data.write_data    = tcw_pkg::CRTC_CURSOR_LO;
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_CUR_LO;
        end
      end
      tcw_pkg::BK_CUR_LO: begin
        out_valid              = 1'b1;
        out_data.write_kind    = tcw_pkg::WK_PORT;
        out_data.write_address = tcw_pkg::CRTC_DATA_PORT;
        out_data.write_data    = pos_r[7:0];
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_CUR_HI_IDX;
        end
      end
      tcw_pkg::BK_CUR_HI_IDX: begin
        out_valid              = 1'b1;
        out_data.write_kind    = tcw_pkg::WK_PORT;
        out_data.write_address = tcw_pkg::CRTC_INDEX_PORT;
        out_data.write_data    = tcw_pkg::CRTC_CURSOR_HI;
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_CUR_HI;
        end
      end
      tcw_pkg::BK_CUR_HI: begin
        out_valid              = 1'b1;
        out_data.write_kind    = tcw_pkg::WK_PORT;
        out_data.write_address = tcw_pkg::CRTC_DATA_PORT;
        out_data.write_data    = pos_r[15:8];
        out_data.last          = 1'b1;
        if (emit_ok) begin
          state_nxt = tcw_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

// ===== verif/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A scoreboard tracks the
// write offset and the text attribute, and from every accepted command it
// predicts the cell memory and CRTC port writes. Each output transaction is
// compared field by field with the oldest predicted write. Stimulus runs a
// directed set of corner cases, random phases under several idling patterns
// and attribute settings, and a long output hold-off.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int CELL_BYTES    = 2;
  localparam int LINE_COLS     = 80;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 50;

  // Op codes the block ignores
  localparam logic [2:0] OP_RESERVED_5 = 3'd5;
  localparam logic [2:0] OP_RESERVED_6 = 3'd6;
  localparam logic [2:0] OP_RESERVED_7 = 3'd7;

  // Predicts the write stream and checks each output transaction against it
  class write_scoreboard;
    tcw_out_t    expected_writes[$];
    logic [15:0] cell_offset;
    logic [7:0]  text_attr;
    int          cell_bytes;
    int          line_cols;
    int          errors;

    function new(int bytes_per_cell, int columns);
      cell_bytes  = bytes_per_cell;
      line_cols   = columns;
      cell_offset = '0;
      text_attr   = ATTR_RESET;
      errors      = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
      text_attr = value;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void push_write(logic kind, logic [15:0] addr, logic [7:0] data);
      tcw_out_t w;
      w.write_kind    = kind;
      w.write_address = addr;
      w.write_data    = data;
      w.last          = 1'b0;
      expected_writes.push_back(w);
    endfunction

    // Character byte, attribute byte, then advance one cell
    function void put_cell(logic [7:0] ch);
      push_write(WK_MEM, cell_offset, ch);
      push_write(WK_MEM, cell_offset + 16'd1, text_attr);
      cell_offset = cell_offset + 16'(cell_bytes);
    endfunction

    function void load_cursor(logic [15:0] pos);
      push_write(WK_PORT, CRTC_INDEX_PORT, CRTC_CURSOR_LO);
      push_write(WK_PORT, CRTC_DATA_PORT, pos[7:0]);
      push_write(WK_PORT, CRTC_INDEX_PORT, CRTC_CURSOR_HI);
      push_write(WK_PORT, CRTC_DATA_PORT, pos[15:8]);
    endfunction

    // Note an accepted command and queue the writes it must cause
    function void note_command(tcw_in_t cmd);
      int          line;
      int          next_line;
      logic [31:0] mag;
      logic [7:0]  digs [MAX_DIGITS];
      int          nd;
      logic [15:0] pos;
      tcw_out_t    final_write;
      line = cell_bytes * line_cols;
      case (cmd.op)
        OP_PRINT_CHAR: put_cell(cmd.char_code);
        OP_NEWLINE: begin
          next_line   = int'(cell_offset) + line - int'(cell_offset) % line;
          cell_offset = 16'(next_line);
        end
        OP_BACKSPACE: begin
          // saturate at zero; nothing is blanked when already there
          if (cell_offset != 16'd0) begin
            if (int'(cell_offset) < cell_bytes) cell_offset = '0;
            else cell_offset = cell_offset - 16'(cell_bytes);
            push_write(WK_MEM, cell_offset + 16'd1, text_attr);
            push_write(WK_MEM, cell_offset, CH_SPACE);
          end
        end
        OP_PRINT_INT: begin
          mag = cmd.number;
          if (mag[31]) begin
            mag = -mag;
            put_cell(CH_MINUS);
          end
          nd = 0;
          do begin
            digs[nd] = 8'(mag % 32'd10);
            mag      = mag / 32'd10;
            nd++;
          end while (mag != 0 && nd < MAX_DIGITS);
          while (nd > 0) begin
            nd--;
            put_cell(CH_ZERO + digs[nd]);
          end
        end
        OP_MOVE_CURSOR: ;
        default: return;
      endcase
      if (cmd.op == OP_MOVE_CURSOR) pos = 16'(cmd.target_row * line_cols + cmd.target_col);
      else pos = 16'(int'(cell_offset) / cell_bytes);
      load_cursor(pos);
      // flag the closing write of this command
      final_write = expected_writes.pop_back();
      final_write.last = 1'b1;
      expected_writes.push_back(final_write);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Check one output transaction against the oldest predicted write
    function void check_write(tcw_out_t got);
      tcw_out_t want;
      if (expected_writes.size() == 0) begin
        $error("unexpected write: kind %0d address %0h data %0h last %0d",
               got.write_kind, got.write_address, got.write_data, got.last);
        errors++;
        return;
      end
      want = expected_writes.pop_front();
      compare_field("write_kind", 16'(want.write_kind), 16'(got.write_kind));
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("write_data", 16'(want.write_data), 16'(got.write_data));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  tcw_in_t     in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  tcw_out_t    out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [1:0]  cfg_paddr   = ADDR_TEXT_ATTR;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  write_scoreboard sb = new(CELL_BYTES, LINE_COLS);

  text_console_writer #(
    .BYTES_PER_CELL(CELL_BYTES),
    .COLUMNS       (LINE_COLS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // Output side: honour a requested hold-off, otherwise stall at random
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_write(out_data);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tcw_in_t make_cmd(logic [2:0] op, logic [7:0] ch, logic [31:0] num,
                                       logic [7:0] row, logic [7:0] col);
    tcw_in_t c;
    c.op         = op;
    c.char_code  = ch;
    c.number     = num;
    c.target_row = row;
    c.target_col = col;
    return c;
  endfunction

  // Random command, all fields random, magnitude spread over every digit count
  function automatic tcw_in_t random_command();
    tcw_in_t     c;
    int          pick;
    logic [31:0] mag;
    mag  = $urandom >> $urandom_range(0, 31);
    c    = make_cmd(OP_PRINT_CHAR, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 1) ? -mag : mag,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    pick = $urandom_range(1, 100);
    if (pick <= 35) c.op = OP_PRINT_CHAR;
    else if (pick <= 47) c.op = OP_NEWLINE;
    else if (pick <= 62) c.op = OP_BACKSPACE;
    else if (pick <= 82) c.op = OP_PRINT_INT;
    else if (pick <= 95) c.op = OP_MOVE_CURSOR;
    else if (pick <= 97) c.op = OP_RESERVED_5;
    else if (pick <= 99) c.op = OP_RESERVED_6;
    else c.op = OP_RESERVED_7;
    return c;
  endfunction

  // Offer one command, idling first at random, and hold it until accepted
  task automatic send_command(input tcw_in_t cmd);
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    sb.note_command(cmd);
  endtask

  // Send random commands until n of them are ones the block acts on
  task automatic send_random(input int n);
    tcw_in_t c;
    int      done;
    done = 0;
    while (done < n) begin
      c = random_command();
      send_command(c);
      if (c.op <= OP_MOVE_CURSOR) done++;
    end
  endtask

  // Drop valid, wait for every predicted write, then let the block settle
  task automatic drain_writes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_TEXT_ATTR;
    cfg_pwdata  <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_attribute(value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases at the reset attribute, no idling
    send_command(make_cmd(OP_BACKSPACE, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_CHAR, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_CHAR, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    send_command(make_cmd(OP_PRINT_CHAR, 8'h41, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_BACKSPACE, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_BACKSPACE, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_INT, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_INT, 8'h00, 32'h7FFF_FFFF, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_INT, 8'h00, 32'h8000_0000, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_INT, 8'h00, 32'hFFFF_FFFF, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_INT, 8'h00, 32'd9, 8'd0, 8'd0));
    send_command(make_cmd(OP_PRINT_INT, 8'h00, -32'sd10, 8'd0, 8'd0));
    send_command(make_cmd(OP_NEWLINE, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_NEWLINE, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_MOVE_CURSOR, 8'h00, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_MOVE_CURSOR, 8'h00, 32'd0, 8'hFF, 8'hFF));
    send_command(make_cmd(OP_MOVE_CURSOR, 8'h00, 32'd0, 8'h00, 8'hFF));
    send_command(make_cmd(OP_MOVE_CURSOR, 8'h00, 32'd0, 8'hFF, 8'h00));
    send_command(make_cmd(OP_RESERVED_5, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    send_command(make_cmd(OP_RESERVED_6, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    send_command(make_cmd(OP_RESERVED_7, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    send_command(make_cmd(OP_PRINT_CHAR, CH_SPACE, 32'd0, 8'd0, 8'd0));
    send_command(make_cmd(OP_BACKSPACE, 8'h00, 32'd0, 8'd0, 8'd0));
    drain_writes();

    // Random phases: none, sender idle, receiver stall, both
    write_attribute(8'h00);
    send_random(PHASE_ITEMS);
    drain_writes();

    write_attribute(8'hFF);
    sender_idle_pct = 52;
    send_random(PHASE_ITEMS);
    drain_writes();

    write_attribute(8'($urandom_range(0, 255)));
    sender_idle_pct = 0;
    recv_stall_pct  = 52;
    send_random(PHASE_ITEMS);
    drain_writes();

    write_attribute(ATTR_RESET);
    sender_idle_pct = 17;
    recv_stall_pct  = 17;
    send_random(PHASE_ITEMS);
    drain_writes();

    // Hold the output off while commands keep coming, so the input backs up
    write_attribute(8'($urandom_range(0, 255)));
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = HOLD_CYCLES;
    send_random(30);

    drain_writes();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
